### rtl/core/packed_date_seconds_converter_macros.svh
`ifndef PACKED_DATE_SECONDS_CONVERTER_MACROS_SVH
`define PACKED_DATE_SECONDS_CONVERTER_MACROS_SVH

// plain clocked check
`define PDSC_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("pdsc check failed");

// implication check
`define PDSC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pdsc implication failed");

`endif

### rtl/core/pdsc_pkg.sv
package pdsc_pkg;

   localparam int NUM_STAGES = 5;

   localparam logic CMD_PACK   = 1'b0;
   localparam logic CMD_UNPACK = 1'b1;

   localparam logic [28:0] DAY_SECONDS      = 29'd86400;
   localparam logic [28:0] SEC_PER_HALF_DAY = 29'd43200;
   localparam logic [28:0] END_OF_YEAR_15   = 29'd504921600;
   localparam logic [24:0] EXTRA_DAY        = 25'd86400;
   localparam logic [15:0] RECIP_675        = 16'd49711;
   localparam int          RECIP_SHIFT      = 25;

   typedef struct packed {
      logic        command;
      logic [15:0] packed_word;
      logic [15:0] half_day_seconds;
      logic [28:0] seconds_in;
   } req_type;

   typedef struct packed {
      logic [28:0] seconds_out;
      logic [15:0] packed_word_out;
      logic [15:0] half_day_seconds_out;
      logic        invalid;
   } rsp_type;

   typedef struct packed {
      logic [NUM_STAGES-1:0] load;
   } pipe_ctrl_type;

   // seconds at the start of a year
   function automatic logic [28:0] year_start(input logic [3:0] y);
      logic [28:0] r;
      case (y)
         4'd0:    r = 29'd0;
         4'd1:    r = 29'd31622400;
         4'd2:    r = 29'd63158400;
         4'd3:    r = 29'd94694400;
         4'd4:    r = 29'd126230400;
         4'd5:    r = 29'd157852800;
         4'd6:    r = 29'd189388800;
         4'd7:    r = 29'd220924800;
         4'd8:    r = 29'd252460800;
         4'd9:    r = 29'd284083200;
         4'd10:   r = 29'd315619200;
         4'd11:   r = 29'd347155200;
         4'd12:   r = 29'd378691200;
         4'd13:   r = 29'd410313600;
         4'd14:   r = 29'd441849600;
         4'd15:   r = 29'd473385600;
         default: r = 29'd0;
      endcase
      return r;
   endfunction

   // seconds before the start of a month in a common year
   function automatic logic [24:0] month_start(input logic [3:0] m);
      logic [24:0] r;
      case (m)
         4'd2:    r = 25'd2678400;
         4'd3:    r = 25'd5097600;
         4'd4:    r = 25'd7776000;
         4'd5:    r = 25'd10368000;
         4'd6:    r = 25'd13046400;
         4'd7:    r = 25'd15638400;
         4'd8:    r = 25'd18316800;
         4'd9:    r = 25'd20995200;
         4'd10:   r = 25'd23587200;
         4'd11:   r = 25'd26265600;
         4'd12:   r = 25'd28857600;
         default: r = 25'd0;
      endcase
      return r;
   endfunction

endpackage

### rtl/core/pdsc_pack_pipe.sv
module pdsc_pack_pipe (
   input  logic                    clock,
   input  pdsc_pkg::pipe_ctrl_type ctrl,
   input  logic [15:0]             packed_word,
   input  logic [15:0]             half_day_seconds,
   output logic [28:0]             seconds,
   output logic                    invalid
);

   localparam int N = pdsc_pkg::NUM_STAGES;

   logic [3:0]  year;
   logic [3:0]  month;
   logic [4:0]  day;
   logic        bad;
   logic [28:0] base_in;
   logic [28:0] dayterm_in;
   logic [28:0] base_ff;
   logic [28:0] dayterm_ff;
   logic [N-1:0] bad_ff;
   logic [28:0] sec_ff [N-1:1];
   logic [28:0] sec_in;

   always_comb begin
      year  = packed_word[15:12];
      month = packed_word[11:8];
      day   = packed_word[5:1];
      bad   = (month == 4'd0) || (day == 5'd0) || (month > 4'd12);
      base_in = pdsc_pkg::year_start(year) + 29'(pdsc_pkg::month_start(month));
      if ((year[1:0] == 2'd0) && (month > 4'd2)) begin
         base_in = base_in + pdsc_pkg::DAY_SECONDS;
      end
      dayterm_in = 29'(day - 5'd1) * pdsc_pkg::DAY_SECONDS + 29'(half_day_seconds);
      if (packed_word[0]) begin
         dayterm_in = dayterm_in + pdsc_pkg::SEC_PER_HALF_DAY;
      end
      sec_in = bad_ff[0] ? 29'd0 : base_ff + dayterm_ff;
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         base_ff    <= base_in;
         dayterm_ff <= dayterm_in;
         bad_ff[0]  <= bad;
      end
      if (ctrl.load[1]) begin
         sec_ff[1] <= sec_in;
         bad_ff[1] <= bad_ff[0];
      end
      for (int k = 2; k < N; k++) begin
         if (ctrl.load[k]) begin
            sec_ff[k] <= sec_ff[k-1];
            bad_ff[k] <= bad_ff[k-1];
         end
      end
   end

   assign seconds = sec_ff[N-1];
   assign invalid = bad_ff[N-1];

endmodule

### rtl/core/pdsc_unpack_pipe.sv
module pdsc_unpack_pipe (
   input  logic                    clock,
   input  pdsc_pkg::pipe_ctrl_type ctrl,
   input  logic [28:0]             seconds_in,
   output logic [15:0]             packed_word,
   output logic [15:0]             half_day_seconds,
   output logic                    invalid
);

   // stage 0: year search
   logic [28:0] s0_ff;
   logic [3:0]  year0_ff;
   logic        oor0_ff;
   logic [15:1] year_hit;
   logic [3:0]  year0_in;

   // stage 1: strip whole years
   logic [24:0] sy1_ff;
   logic [3:0]  year1_ff;
   logic        leap1_ff;
   logic        oor1_ff;
   logic [28:0] sy1_full;

   // stage 2: month search and strip
   logic [21:0] sm2_ff;
   logic [3:0]  month2_ff;
   logic [3:0]  year2_ff;
   logic        oor2_ff;
   logic [10:0] month_hit;
   logic [3:0]  month2_in;
   logic [24:0] month_sub;
   logic [24:0] thresh;
   logic [24:0] sm2_full;

   // stage 3: reciprocal product for the half-day quotient
   logic [31:0] prod3_ff;
   logic [21:0] sm3_ff;
   logic [3:0]  month3_ff;
   logic [3:0]  year3_ff;
   logic        oor3_ff;

   // stage 4: result
   logic [15:0] packed4_ff;
   logic [15:0] rem4_ff;
   logic        oor4_ff;
   logic [5:0]  halves;
   logic [21:0] rem_full;

   function automatic logic s0_ff_cmp(input logic [28:0] s, input logic [3:0] y);
      return s >= pdsc_pkg::year_start(y);
   endfunction

   always_comb begin
      for (int i = 1; i < 16; i++) begin
         year_hit[i] = s0_ff_cmp(seconds_in, 4'(i));
      end
      year0_in = 4'($countones(year_hit));

      sy1_full = s0_ff - pdsc_pkg::year_start(year0_ff);

      for (int i = 0; i < 11; i++) begin
         thresh = pdsc_pkg::month_start(4'(i + 2));
         if ((i != 0) && leap1_ff) begin
            thresh = thresh + pdsc_pkg::EXTRA_DAY;
         end
         month_hit[i] = (sy1_ff >= thresh);
      end
      month2_in = 4'($countones(month_hit));
      month_sub = pdsc_pkg::month_start(month2_in + 4'd1);
      if ((month2_in > 4'd1) && leap1_ff) begin
         month_sub = month_sub + pdsc_pkg::EXTRA_DAY;
      end
      sm2_full = sy1_ff - month_sub;

      halves   = prod3_ff[pdsc_pkg::RECIP_SHIFT+5:pdsc_pkg::RECIP_SHIFT];
      rem_full = sm3_ff - 22'(halves) * 22'(pdsc_pkg::SEC_PER_HALF_DAY);
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         s0_ff    <= seconds_in;
         year0_ff <= year0_in;
         oor0_ff  <= (seconds_in >= pdsc_pkg::END_OF_YEAR_15);
      end
      if (ctrl.load[1]) begin
         sy1_ff   <= sy1_full[24:0];
         year1_ff <= year0_ff;
         leap1_ff <= (year0_ff[1:0] == 2'd0);
         oor1_ff  <= oor0_ff;
      end
      if (ctrl.load[2]) begin
         sm2_ff    <= sm2_full[21:0];
         month2_ff <= month2_in;
         year2_ff  <= year1_ff;
         oor2_ff   <= oor1_ff;
      end
      if (ctrl.load[3]) begin
         prod3_ff  <= 32'(sm2_ff[21:6]) * 32'(pdsc_pkg::RECIP_675);
         sm3_ff    <= sm2_ff;
         month3_ff <= month2_ff;
         year3_ff  <= year2_ff;
         oor3_ff   <= oor2_ff;
      end
      if (ctrl.load[4]) begin
         oor4_ff <= oor3_ff;
         if (oor3_ff) begin
            packed4_ff <= 16'd0;
            rem4_ff    <= 16'd0;
         end else begin
            packed4_ff <= {year3_ff, month3_ff + 4'd1, 8'(halves) + 8'd2};
            rem4_ff    <= rem_full[15:0];
         end
      end
   end

   assign packed_word      = packed4_ff;
   assign half_day_seconds = rem4_ff;
   assign invalid          = oor4_ff;

endmodule

### rtl/core/packed_date_seconds_converter.sv
// packed date <-> seconds converter
// request channel: req_valid / req_stall / req_payload (pdsc_pkg::req_type).
//   command 0 packs year, month, day and afternoon bit plus half-day seconds
//   into seconds from the start of year 0; command 1 unpacks seconds.
// response channel: rsp_valid / rsp_stall / rsp_payload (pdsc_pkg::rsp_type),
//   one response per request, in request order.
// throughput: one request per cycle while rsp_stall is low; five register
//   stages, set by the year search, the year and month strip, the
//   reciprocal multiply for the half-day quotient and the remainder stage.
// fields of the unused direction read as zero; invalid flags a zero day or
//   month outside 1..12 when packing, or seconds past the end of year 15.
// reset: synchronous, clears all stage valids; the pipeline is then empty.
// stall: a held response keeps its payload; stages behind it fill up
//   bubbles first, and req_stall rises only once every stage is occupied.
`include "packed_date_seconds_converter_macros.svh"

module packed_date_seconds_converter (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_stall,
   input  pdsc_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output pdsc_pkg::rsp_type rsp_payload
);

   localparam int N = pdsc_pkg::NUM_STAGES;

   pdsc_pkg::pipe_ctrl_type ctrl;
   logic [N-1:0] valid_ff;
   logic [N-1:0] valid_in;
   logic [N-1:0] cmd_ff;
   logic [28:0]  pack_seconds;
   logic         pack_invalid;
   logic [15:0]  unpack_word;
   logic [15:0]  unpack_half;
   logic         unpack_invalid;

   always_comb begin
      ctrl.load[N-1] = !valid_ff[N-1] || !rsp_stall;
      for (int k = N - 2; k >= 0; k--) begin
         ctrl.load[k] = !valid_ff[k] || ctrl.load[k+1];
      end
      for (int k = 0; k < N; k++) begin
         if (ctrl.load[k]) begin
            valid_in[k] = (k == 0) ? req_valid : valid_ff[(k == 0) ? 0 : k - 1];
         end else begin
            valid_in[k] = valid_ff[k];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.load[0]) begin
         cmd_ff[0] <= req_payload.command;
      end
      for (int k = 1; k < N; k++) begin
         if (ctrl.load[k]) begin
            cmd_ff[k] <= cmd_ff[k-1];
         end
      end
   end

   pdsc_pack_pipe u_pack (
      .clock            (clock),
      .ctrl             (ctrl),
      .packed_word      (req_payload.packed_word),
      .half_day_seconds (req_payload.half_day_seconds),
      .seconds          (pack_seconds),
      .invalid          (pack_invalid)
   );

   pdsc_unpack_pipe u_unpack (
      .clock            (clock),
      .ctrl             (ctrl),
      .seconds_in       (req_payload.seconds_in),
      .packed_word      (unpack_word),
      .half_day_seconds (unpack_half),
      .invalid          (unpack_invalid)
   );

   always_comb begin
      if (cmd_ff[N-1] == pdsc_pkg::CMD_UNPACK) begin
         rsp_payload.seconds_out          = 29'd0;
         rsp_payload.packed_word_out      = unpack_word;
         rsp_payload.half_day_seconds_out = unpack_half;
         rsp_payload.invalid              = unpack_invalid;
      end else begin
         rsp_payload.seconds_out          = pack_seconds;
         rsp_payload.packed_word_out      = 16'd0;
         rsp_payload.half_day_seconds_out = 16'd0;
         rsp_payload.invalid              = pack_invalid;
      end
   end

   assign rsp_valid = valid_ff[N-1];
   assign req_stall = !ctrl.load[0];

   `PDSC_ASSERT_IMP(a_accept_fills, clock, reset, req_valid && !req_stall, ##1 valid_ff[0])
   `PDSC_ASSERT_IMP(a_invalid_zero, clock, reset, rsp_valid && rsp_payload.invalid, (rsp_payload.seconds_out == 29'd0) && (rsp_payload.packed_word_out == 16'd0) && (rsp_payload.half_day_seconds_out == 16'd0))
   `PDSC_ASSERT_IMP(a_rem_range, clock, reset, rsp_valid && (cmd_ff[N-1] == pdsc_pkg::CMD_UNPACK), rsp_payload.half_day_seconds_out < 16'd43200)
   `PDSC_ASSERT(a_stall_full, clock, reset, !req_stall || (valid_ff == {N{1'b1}}))

endmodule
